[hw/rtl/ctmd_pkg.sv]
// Shared types, register codes and pixel mask function for the color threshold mask block.
package ctmd_pkg;

  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 11;
  localparam int unsigned WIN_SIZE    = 3;
  localparam int unsigned WIN_BITS    = WIN_SIZE * WIN_SIZE;
  localparam logic [10:0] WIDTH_RESET  = 11'd640;
  localparam logic [10:0] HEIGHT_RESET = 11'd480;
  localparam logic [7:0]  BRIGHT_RESET = 8'd100;
  localparam logic [7:0]  DIFF_RESET   = 8'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET       = 3'd0,
    REG_BLUE_BRIGHT  = 3'd1,
    REG_RED_BRIGHT   = 3'd2,
    REG_BLUE_DIFF    = 3'd3,
    REG_RED_DIFF     = 3'd4,
    REG_WIDTH        = 3'd5,
    REG_HEIGHT       = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic       target_is_blue;
    logic [7:0] blue_brightness;
    logic [7:0] red_brightness;
    logic [7:0] blue_diff;
    logic [7:0] red_diff;
  } ctmd_thr_t;

  // 0 acts as 1, above the maximum acts as the maximum
  function automatic int unsigned eff_size(input logic [10:0] v, input int unsigned max);
    int unsigned r;
    r = 32'(v);
    if (r == 0) r = 1;
    else if (r > max) r = max;
    return r;
  endfunction

  function automatic logic mask_of(input logic [7:0] b, input logic [7:0] g,
                                   input logic [7:0] r, input ctmd_thr_t thr);
    logic [22:0] sum;
    logic [8:0]  gray;
    logic [8:0]  d;
    logic [7:0]  bl;
    logic [7:0]  dl;
    sum  = 23'd1868 * 23'(b) + 23'd9617 * 23'(g) + 23'd4899 * 23'(r) + 23'd8192;
    gray = sum[22:14];
    if (thr.target_is_blue) begin
      d  = {1'b0, b} - {1'b0, r};
      bl = thr.blue_brightness;
      dl = thr.blue_diff;
    end else begin
      d  = {1'b0, r} - {1'b0, b};
      bl = thr.red_brightness;
      dl = thr.red_diff;
    end
    return (gray > {1'b0, bl}) && !d[8] && (d[7:0] > dl);
  endfunction

endpackage

[hw/rtl/ctmd_cfg_regs.sv]
// Configuration registers with effective frame size and frame restart pulse.
module ctmd_cfg_regs
  import ctmd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned WW = $clog2(MAX_WIDTH + 1),
  parameter int unsigned HW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr,
  input  logic [CFG_IDX_W-1:0]  index,
  input  logic [CFG_DATA_W-1:0] data,
  output ctmd_thr_t             thr,
  output logic [WW-1:0]         w_eff,
  output logic [HW-1:0]         h_eff,
  output logic                  restart
);

  always_ff @(posedge clk) begin
    if (rst) begin
      thr.target_is_blue  <= 1'b0;
      thr.blue_brightness <= BRIGHT_RESET;
      thr.red_brightness  <= BRIGHT_RESET;
      thr.blue_diff       <= DIFF_RESET;
      thr.red_diff        <= DIFF_RESET;
      w_eff <= WW'(eff_size(WIDTH_RESET, MAX_WIDTH));
      h_eff <= HW'(eff_size(HEIGHT_RESET, MAX_HEIGHT));
    end else if (wr) begin
      unique case (cfg_reg_t'(index))
        REG_TARGET:      thr.target_is_blue  <= data[0];
        REG_BLUE_BRIGHT: thr.blue_brightness <= data[7:0];
        REG_RED_BRIGHT:  thr.red_brightness  <= data[7:0];
        REG_BLUE_DIFF:   thr.blue_diff       <= data[7:0];
        REG_RED_DIFF:    thr.red_diff        <= data[7:0];
        REG_WIDTH:       w_eff <= WW'(eff_size(data, MAX_WIDTH));
        REG_HEIGHT:      h_eff <= HW'(eff_size(data, MAX_HEIGHT));
        default: ;
      endcase
    end
  end

  assign restart = wr && ((cfg_reg_t'(index) == REG_WIDTH) ||
                          (cfg_reg_t'(index) == REG_HEIGHT));

endmodule

[hw/rtl/ctmd_line_store.sv]
// Two-row mask line store, registered read with write forwarding.
module ctmd_line_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [1:0]    wr_data,
  output logic [1:0]    rd_data
);

  logic [1:0] mem [DEPTH];
  logic [1:0] rd_raw;
  logic [1:0] fwd_data;
  logic       fwd;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_raw   <= mem[rd_addr];
      fwd      <= wr_en && (wr_addr == rd_addr);
      fwd_data <= wr_data;
    end
  end

  assign rd_data = fwd ? fwd_data : rd_raw;

endmodule

[hw/rtl/color_threshold_mask_dilate_top.sv]
// Color threshold mask with 3x3 dilation: input register, window logic, result register.
// Pipeline: an accepted item is held in the input register, and its result leaves through the result register;
// the result for a pixel comes with the input item one row plus one pixel later.
// Throughput: one item per cycle while the result is not stalled, set by the line store read and window update.
// Reset (rst, synchronous): counters, window and handshake state cleared, registers to
// defaults; the line store is not cleared and needs no clearing pass.
module color_threshold_mask_dilate_top
  import ctmd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  kind,
  input  logic [7:0]            blue_level,
  input  logic [7:0]            green_level,
  input  logic [7:0]            red_level,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  mask_bit,
  output logic                  row_end,
  output logic                  frame_end
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 2);
  localparam int unsigned OW = $clog2(MAX_HEIGHT);
  localparam int unsigned XW = (CW > WW ? CW : WW) + 1;
  localparam int unsigned YW = (RW > HW ? RW : HW) + 1;

  ctmd_thr_t       thr;
  logic [WW-1:0]   w_eff;
  logic [HW-1:0]   h_eff;
  logic            restart;

  logic            a_valid;
  logic            a_kind;
  logic [7:0]      a_blue;
  logic [7:0]      a_green;
  logic [7:0]      a_red;

  logic [CW-1:0]       in_column, in_column_next;
  logic [RW-1:0]       in_row, in_row_next;
  logic [CW-1:0]       out_column, out_column_next;
  logic [OW-1:0]       out_row, out_row_next;
  logic [WIN_BITS-1:0] window, window_next, win_shift;

  logic       accept;
  logic       proceed;
  logic [1:0] rd_data;
  logic       store_wr;
  logic       pix_bit;
  logic       draining;
  logic       emit;
  logic       emit_mask;
  logic       emit_start;
  logic       emit_mid;
  logic       left;
  logic       last_col;
  logic       last_row;
  logic [2:0] rows;
  logic [2:0] acc_start;
  logic [2:0] acc_mid;

  assign cfg_ready = 1'b1;

  ctmd_cfg_regs #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .WW        (WW),
    .HW        (HW)
  ) u_cfg (
    .clk    (clk),
    .rst    (rst),
    .wr     (cfg_valid && cfg_ready),
    .index  (cfg_index),
    .data   (cfg_data),
    .thr    (thr),
    .w_eff  (w_eff),
    .h_eff  (h_eff),
    .restart(restart)
  );

  assign proceed  = a_valid && (!out_valid || !out_stall);
  assign in_stall = a_valid && !proceed;
  assign accept   = in_valid && !in_stall;

  ctmd_line_store #(
    .DEPTH(MAX_WIDTH),
    .AW   (CW)
  ) u_store (
    .clk    (clk),
    .rd_en  (accept),
    .rd_addr(in_column_next),
    .wr_en  (store_wr),
    .wr_addr(in_column),
    .wr_data({rd_data[0], pix_bit}),
    .rd_data(rd_data)
  );

  always_comb begin
    in_column_next  = in_column;
    in_row_next     = in_row;
    out_column_next = out_column;
    out_row_next    = out_row;
    window_next     = window;
    store_wr        = 1'b0;
    emit            = 1'b0;

    draining   = YW'(in_row) >= YW'(h_eff);
    pix_bit    = draining ? 1'b0 : mask_of(a_blue, a_green, a_red, thr);
    emit_start = (in_column == '0) && (in_row >= RW'(2));
    emit_mid   = (in_column != '0) && (in_row != '0);
    rows       = {(YW'(out_row) + YW'(1)) < YW'(h_eff), 1'b1, out_row != '0};
    left       = out_column != '0;
    last_col   = (XW'(out_column) + XW'(1)) >= XW'(w_eff);
    last_row   = (YW'(out_row) + YW'(1)) >= YW'(h_eff);
    win_shift  = {window[5:0], pix_bit, rd_data[0], rd_data[1]};
    acc_start  = (window[2:0] & rows) | (left ? (window[5:3] & rows) : 3'b000);
    acc_mid    = (win_shift[5:3] & rows) | (win_shift[2:0] & rows) |
                 (left ? (win_shift[8:6] & rows) : 3'b000);
    emit_mask  = emit_start ? |acc_start : |acc_mid;

    if (restart) begin
      in_column_next  = '0;
      in_row_next     = '0;
      out_column_next = '0;
      out_row_next    = '0;
      window_next     = '0;
    end else if (proceed && !(a_kind && !draining)) begin
      emit = emit_start || emit_mid;
      if (emit) begin
        if (last_col) begin
          out_column_next = '0;
          out_row_next    = out_row + OW'(1);
        end else begin
          out_column_next = out_column + CW'(1);
        end
      end
      if (emit_start && last_col && last_row) begin
        in_column_next  = '0;
        in_row_next     = '0;
        out_column_next = '0;
        out_row_next    = '0;
        window_next     = '0;
      end else begin
        window_next = win_shift;
        store_wr    = 1'b1;
        if ((XW'(in_column) + XW'(1)) >= XW'(w_eff)) begin
          in_column_next = '0;
          in_row_next    = in_row + RW'(1);
        end else begin
          in_column_next = in_column + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
      window     <= '0;
      a_valid    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      in_column  <= in_column_next;
      in_row     <= in_row_next;
      out_column <= out_column_next;
      out_row    <= out_row_next;
      window     <= window_next;
      if (accept) begin
        a_valid <= 1'b1;
      end else if (proceed) begin
        a_valid <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_kind  <= kind;
      a_blue  <= blue_level;
      a_green <= green_level;
      a_red   <= red_level;
    end
    if (emit) begin
      mask_bit  <= emit_mask;
      row_end   <= last_col;
      frame_end <= last_col && last_row;
    end
  end

endmodule

[hw/rtl/ctmd_checker.sv]
// Port-level checks for the color threshold mask block, bound to the top level.
module ctmd_port_checks (
  input logic clk,
  input logic rst,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic mask_bit,
  input logic row_end,
  input logic frame_end
);

  // frame end only on a row end
  a_frame_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> row_end)
    else $error("frame_end without row_end");

  // input side backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(mask_bit) && $stable(row_end)
      && $stable(frame_end))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind color_threshold_mask_dilate_top ctmd_port_checks u_chk (
  .clk      (clk),
  .rst      (rst),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .mask_bit (mask_bit),
  .row_end  (row_end),
  .frame_end(frame_end)
);
